[rtl/dfi_pkg.sv]
// Shared types and constants for the DAB frequency-interleave map.
// No dependencies; used by every module of the block.
`default_nettype none

package dfi_pkg;

  // Symbol size limit and derived widths
  localparam int unsigned MaxFftSizeDefault = 2048;
  localparam int unsigned TableAwMax        = 11;

  // Fixed field widths
  localparam int unsigned LogW    = 4;
  localparam int unsigned CfgW    = 11;
  localparam int unsigned IndexW  = 11;
  localparam int unsigned OffsetW = 11;
  localparam int unsigned BoundW  = 12;

  // Register indexes on the configuration port
  localparam logic [1:0] RegFftSizeLog2 = 2'd0;
  localparam logic [1:0] RegIncrement   = 2'd1;
  localparam logic [1:0] RegLowerBound  = 2'd2;
  localparam logic [1:0] RegCarrierCnt  = 2'd3;

  // Register reset values (mode I)
  localparam logic [LogW-1:0] FftSizeLog2Rst = 4'd11;
  localparam logic [CfgW-1:0] IncrementRst   = 11'd511;
  localparam logic [CfgW-1:0] LowerBoundRst  = 11'd256;
  localparam logic [CfgW-1:0] CarrierCntRst  = 11'd1536;

  // Smallest symbol size exponent
  localparam logic [LogW-1:0] MinFftLog2 = 4'd8;

  // Table write port from the build sequencer
  typedef struct packed {
    logic                  en;
    logic [TableAwMax-1:0] addr;
    logic [OffsetW-1:0]    data;
  } ram_wr_t;

endpackage

`default_nettype wire

[rtl/dab_frequency_interleave_map.sv]
// DAB frequency-interleave map: builds the carrier offset table, then answers lookups.
// Build: after reset or any register write, walks all N positions (N = symbol size);
// no lookup is taken meanwhile. Lookup: the table read is registered, then the result;
// one lookup in flight, so the next is accepted only once the last result is taken.
// Reset: registers return to mode I values and a rebuild starts at once.
// Depends on dfi_pkg, dfi_build_ctrl and dfi_step_unit.
`default_nettype none

module dab_frequency_interleave_map #(
  parameter int unsigned MAX_FFT_SIZE = dfi_pkg::MaxFftSizeDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_index_i,
  input  logic [dfi_pkg::CfgW-1:0]        cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [dfi_pkg::IndexW-1:0]      carrier_index_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [dfi_pkg::OffsetW-1:0] carrier_offset_o,
  output logic                            index_valid_o
);
  import dfi_pkg::*;

  localparam int unsigned AW = $clog2(MAX_FFT_SIZE);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StResp = 2'd2;

  logic [LogW-1:0] fft_size_log2_q;
  logic [CfgW-1:0] increment_q;
  logic [CfgW-1:0] lower_bound_q;
  logic [CfgW-1:0] carrier_count_q;

  ram_wr_t      wr;
  logic         build_busy;
  logic [AW:0]  fill_count;

  logic [1:0]         state_q, state_d;
  logic [IndexW-1:0]  idx_q;
  logic [OffsetW-1:0] rd_data_q;
  logic [OffsetW-1:0] offset_q, offset_d;
  logic               valid_q, valid_d;
  logic               in_fire;

  logic [OffsetW-1:0] table_mem [MAX_FFT_SIZE];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fft_size_log2_q <= FftSizeLog2Rst;
      increment_q     <= IncrementRst;
      lower_bound_q   <= LowerBoundRst;
      carrier_count_q <= CarrierCntRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegFftSizeLog2: fft_size_log2_q <= cfg_data_i[LogW-1:0];
        RegIncrement:   increment_q     <= cfg_data_i;
        RegLowerBound:  lower_bound_q   <= cfg_data_i;
        RegCarrierCnt:  carrier_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dfi_build_ctrl #(
    .MAX_FFT_SIZE(MAX_FFT_SIZE)
  ) u_build (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (cfg_we_i),
    .fft_size_log2_i(fft_size_log2_q),
    .increment_i    (increment_q),
    .lower_bound_i  (lower_bound_q),
    .carrier_count_i(carrier_count_q),
    .wr_o           (wr),
    .busy_o         (build_busy),
    .fill_count_o   (fill_count)
  );

  assign in_ready_o = (state_q == StIdle) && !build_busy && !cfg_we_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Offset table: one write port for the build, one registered read for lookups
  always_ff @(posedge clk_i) begin
    if (wr.en) begin
      table_mem[wr.addr[AW-1:0]] <= wr.data;
    end
    if (in_fire) begin
      rd_data_q <= table_mem[carrier_index_i[AW-1:0]];
      idx_q     <= carrier_index_i;
    end
  end

  always_comb begin
    state_d  = state_q;
    offset_d = offset_q;
    valid_d  = valid_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d = StRead;
        end
      end
      StRead: begin
        // Drop entries beyond what this build wrote, and indexes past the count
        valid_d  = (idx_q < carrier_count_q);
        offset_d = (valid_d && (BoundW'(idx_q) < BoundW'(fill_count))) ? rd_data_q : '0;
        state_d  = StResp;
      end
      StResp: begin
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    offset_q <= offset_d;
    valid_q  <= valid_d;
  end

  assign out_valid_o      = (state_q == StResp);
  assign carrier_offset_o = offset_q;
  assign index_valid_o    = valid_q;

  // No lookup is taken while the table is being built
  a_no_lookup_in_build : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> !build_busy)
    else $error("lookup accepted during table build");

  // A register write always restarts the build
  a_cfg_restarts_build : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> build_busy)
    else $error("register write did not restart the build");

  // An invalid index reports a zero offset
  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !index_valid_o) |-> (carrier_offset_o == '0))
    else $error("non-zero offset on invalid index");

  // A result is presented once its lookup has passed through the read state
  a_result_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> ##2 out_valid_o)
    else $error("lookup result latency broken");

endmodule

`default_nettype wire

[rtl/dfi_step_unit.sv]
// Step unit: one congruential step x -> (13x + increment) mod N,
// plus the keep decision and centred offset of x. Depends on dfi_pkg.
`default_nettype none

module dfi_step_unit #(
  parameter int unsigned SW = 11
) (
  input  logic [SW-1:0]                 x_i,
  input  logic [dfi_pkg::CfgW-1:0]      increment_i,
  input  logic [SW-1:0]                 mask_i,
  input  logic [SW-1:0]                 half_i,
  input  logic [dfi_pkg::BoundW-1:0]    lower_i,
  input  logic [dfi_pkg::BoundW-1:0]    upper_i,
  output logic [SW-1:0]                 next_x_o,
  output logic                          keep_o,
  output logic [dfi_pkg::OffsetW-1:0]   offset_o
);
  import dfi_pkg::*;

  localparam int unsigned ProdW = SW + 4;
  localparam int unsigned SumW  = ((ProdW > CfgW) ? ProdW : CfgW) + 1;

  logic [ProdW-1:0]  prod;
  logic [SumW-1:0]   sum;
  logic [BoundW-1:0] x_ext;
  logic [BoundW-1:0] diff;

  // 13x as shift-and-add, then mask for the power-of-two modulus
  assign prod     = ProdW'({x_i, 3'b000}) + ProdW'({x_i, 2'b00}) + ProdW'(x_i);
  assign sum      = SumW'(prod) + SumW'(increment_i);
  assign next_x_o = sum[SW-1:0] & mask_i;

  assign x_ext    = BoundW'(x_i);
  assign keep_o   = (x_i != half_i) && (x_ext >= lower_i) && (x_ext <= upper_i);
  assign diff     = x_ext - BoundW'(half_i);
  assign offset_o = diff[OffsetW-1:0];

endmodule

`default_nettype wire

[rtl/dfi_build_ctrl.sv]
// Build sequencer: walks the sequence one step a cycle through the
// step unit and writes kept offsets to the table. Depends on dfi_pkg and dfi_step_unit.
`default_nettype none

module dfi_build_ctrl #(
  parameter int unsigned MAX_FFT_SIZE = dfi_pkg::MaxFftSizeDefault
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [dfi_pkg::LogW-1:0]               fft_size_log2_i,
  input  logic [dfi_pkg::CfgW-1:0]               increment_i,
  input  logic [dfi_pkg::CfgW-1:0]               lower_bound_i,
  input  logic [dfi_pkg::CfgW-1:0]               carrier_count_i,
  output dfi_pkg::ram_wr_t                       wr_o,
  output logic                                   busy_o,
  output logic [$clog2(MAX_FFT_SIZE):0]          fill_count_o
);
  import dfi_pkg::*;

  localparam int unsigned     SW      = $clog2(MAX_FFT_SIZE);
  localparam logic [LogW-1:0] MaxLog2 = LogW'(SW);

  logic            busy_q, busy_d;
  logic [SW-1:0]   x_q, x_d;
  logic [SW:0]     step_q, step_d;
  logic [SW:0]     fill_q, fill_d;

  logic [LogW-1:0]   lg_eff;
  logic [SW:0]       n;
  logic [SW:0]       n_minus_1;
  logic [SW-1:0]     mask;
  logic [SW-1:0]     half;
  logic [BoundW-1:0] lower;
  logic [BoundW-1:0] upper;
  logic [SW-1:0]     next_x;
  logic              keep;
  logic [OffsetW-1:0] offset;
  logic              stepping;

  // Clamp the exponent to the supported range
  always_comb begin
    if (fft_size_log2_i < MinFftLog2) begin
      lg_eff = MinFftLog2;
    end else if (fft_size_log2_i > MaxLog2) begin
      lg_eff = MaxLog2;
    end else begin
      lg_eff = fft_size_log2_i;
    end
  end

  assign n         = (SW+1)'(1) << lg_eff;
  assign n_minus_1 = n - (SW+1)'(1);
  assign mask      = n_minus_1[SW-1:0];
  assign half      = n[SW:1];
  assign lower     = BoundW'(lower_bound_i);
  assign upper     = BoundW'(lower_bound_i) + BoundW'(carrier_count_i);

  dfi_step_unit #(
    .SW(SW)
  ) u_step (
    .x_i        (x_q),
    .increment_i(increment_i),
    .mask_i     (mask),
    .half_i     (half),
    .lower_i    (lower),
    .upper_i    (upper),
    .next_x_o   (next_x),
    .keep_o     (keep),
    .offset_o   (offset)
  );

  assign stepping = busy_q && (step_q != n);

  always_comb begin
    busy_d = busy_q;
    x_d    = x_q;
    step_d = step_q;
    fill_d = fill_q;
    if (start_i) begin
      busy_d = 1'b1;
      x_d    = '0;
      step_d = '0;
      fill_d = '0;
    end else if (stepping) begin
      x_d    = next_x;
      step_d = step_q + (SW+1)'(1);
      if (keep) begin
        fill_d = fill_q + (SW+1)'(1);
      end
    end else if (busy_q) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      x_q    <= '0;
      step_q <= '0;
      fill_q <= '0;
    end else begin
      busy_q <= busy_d;
      x_q    <= x_d;
      step_q <= step_d;
      fill_q <= fill_d;
    end
  end

  // fill_q stays below N while stepping, so its low bits address the table
  assign wr_o.en      = stepping && keep && !start_i;
  assign wr_o.addr    = TableAwMax'(fill_q[SW-1:0]);
  assign wr_o.data    = offset;
  assign busy_o       = busy_q;
  assign fill_count_o = fill_q;

endmodule

`default_nettype wire

[dv/dfi_lookup_checker.sv]
`timescale 1ns / 1ps
// Lookup checker for the DAB frequency-interleave map: mirrors the register writes, rebuilds
// the carrier offset table and compares every returned offset in order of issue.
// Depends on dfi_pkg only; watches the block's ports and reports a failure count.

module dfi_lookup_checker #(
  parameter int unsigned MaxFftSize = dfi_pkg::MaxFftSizeDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_index_i,
  input  logic [dfi_pkg::CfgW-1:0]           cfg_data_i,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic [dfi_pkg::IndexW-1:0]         carrier_index_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic signed [dfi_pkg::OffsetW-1:0] carrier_offset_i,
  input  logic                               index_valid_i,
  output int unsigned                        fail_count_o
);
  import dfi_pkg::*;

  localparam int unsigned ReportCap = 200;

  typedef struct packed {
    logic signed [OffsetW-1:0] offset;
    logic                      valid;
  } lookup_t;

  logic [LogW-1:0]    fft_log2_q;
  logic [CfgW-1:0]    increment_q;
  logic [CfgW-1:0]    lower_bound_q;
  logic [CfgW-1:0]    carrier_cnt_q;
  logic [OffsetW-1:0] offset_lut [MaxFftSize];
  int unsigned        fill_q;
  bit                 table_stale;
  lookup_t            pending_q [$];
  int unsigned        mismatches;

  // Walk the congruential sequence once and keep the in-band values
  function automatic void rebuild_offsets();
    int unsigned lg, n, half, upper, x, diff;
    lg = fft_log2_q;
    if (lg < MinFftLog2) lg = MinFftLog2;
    if (lg > TableAwMax) lg = TableAwMax;
    n = 1 << lg;
    if (n > MaxFftSize) n = MaxFftSize;
    half  = n / 2;
    upper = lower_bound_q + carrier_cnt_q;
    x = 0;
    fill_q = 0;
    for (int unsigned pos = 0; pos < n; pos++) begin
      if (x != half && x >= lower_bound_q && x <= upper && fill_q < MaxFftSize) begin
        diff = x - half;
        offset_lut[fill_q] = diff[OffsetW-1:0];
        fill_q++;
      end
      x = (13 * x + increment_q) % n;
    end
  endfunction

  function automatic lookup_t predict_lookup(input logic [IndexW-1:0] idx);
    lookup_t r;
    r.offset = '0;
    r.valid  = 1'b0;
    if (table_stale) begin
      rebuild_offsets();
      table_stale = 1'b0;
    end
    if (idx < carrier_cnt_q) begin
      r.valid = 1'b1;
      // a short table answers zero past its last kept value
      if (idx < fill_q) r.offset = offset_lut[idx];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    lookup_t want;
    if (!rst_ni) begin
      fft_log2_q    = FftSizeLog2Rst;
      increment_q   = IncrementRst;
      lower_bound_q = LowerBoundRst;
      carrier_cnt_q = CarrierCntRst;
      fill_q        = 0;
      table_stale   = 1'b1;
      mismatches    = 0;
      pending_q.delete();
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_q.size() == 0) begin
          if (mismatches < ReportCap)
            $display("%0t: unexpected result, offset %0d valid %0b", $time,
                     carrier_offset_i, index_valid_i);
          mismatches++;
        end else begin
          want = pending_q.pop_front();
          if (carrier_offset_i !== want.offset) begin
            if (mismatches < ReportCap)
              $display("%0t: carrier_offset expected %0d, actual %0d", $time,
                       want.offset, carrier_offset_i);
            mismatches++;
          end
          if (index_valid_i !== want.valid) begin
            if (mismatches < ReportCap)
              $display("%0t: index_valid expected %0b, actual %0b", $time,
                       want.valid, index_valid_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) pending_q.push_back(predict_lookup(carrier_index_i));
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegFftSizeLog2: fft_log2_q    = cfg_data_i[LogW-1:0];
          RegIncrement:   increment_q   = cfg_data_i;
          RegLowerBound:  lower_bound_q = cfg_data_i;
          RegCarrierCnt:  carrier_cnt_q = cfg_data_i;
          default: ;
        endcase
        table_stale = 1'b1;
      end
      // outstanding lookups count against the run until they come back
      fail_count_o <= mismatches + pending_q.size();
    end
  end

endmodule

[dv/tb_dab_frequency_interleave_map.sv]
`timescale 1ns / 1ps
// Testbench top for the DAB frequency-interleave map: drives register phases and lookups
// with random gaps and stalls. Depends on dfi_pkg, the block and dfi_lookup_checker.

module tb_dab_frequency_interleave_map;
  import dfi_pkg::*;

  localparam int unsigned ItemTarget  = 1450;
  localparam int unsigned QuietLimit  = 10000;
  localparam int unsigned DrainCycles = 20;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [1:0]                cfg_index_i;
  logic [CfgW-1:0]           cfg_data_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [IndexW-1:0]         carrier_index_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic signed [OffsetW-1:0] carrier_offset_o;
  logic                      index_valid_o;
  int unsigned               fail_count;

  int unsigned items_sent;
  int unsigned results_taken;
  bit          in_calm;
  bit          out_calm;

  dab_frequency_interleave_map u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .carrier_index_i (carrier_index_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .carrier_offset_o(carrier_offset_o),
    .index_valid_o   (index_valid_o)
  );

  dfi_lookup_checker u_lookup_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .carrier_index_i (carrier_index_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .carrier_offset_i(carrier_offset_o),
    .index_valid_i   (index_valid_o),
    .fail_count_o    (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  // Hold valid across back-to-back lookups; drop it only ahead of a gap
  task automatic put_lookup(input logic [IndexW-1:0] idx);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
    gap = pick_wait(in_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    carrier_index_i <= idx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Wait until every lookup in flight has returned
  task automatic settle();
    in_valid_i <= 1'b0;
    while (results_taken != items_sent) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] sel, input logic [CfgW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= value;
    @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [3:0] mask, input logic [CfgW-1:0] lg,
                              input logic [CfgW-1:0] inc, input logic [CfgW-1:0] lb,
                              input logic [CfgW-1:0] cnt);
    settle();
    if (mask[RegFftSizeLog2]) write_reg(RegFftSizeLog2, lg);
    if (mask[RegIncrement])   write_reg(RegIncrement, inc);
    if (mask[RegLowerBound])  write_reg(RegLowerBound, lb);
    if (mask[RegCarrierCnt])  write_reg(RegCarrierCnt, cnt);
    cfg_we_i <= 1'b0;
  endtask

  // Result side: random stall before each transaction, with calm stretches
  initial begin : result_sink
    int unsigned stall;
    out_ready_i   <= 1'b0;
    results_taken <= 0;
    out_calm = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      stall = pick_wait(out_calm);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      results_taken <= results_taken + 1;
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if (!rst_ni || cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    logic [IndexW-1:0] picks [$];
    logic [CfgW-1:0]   lg_v, inc_v, lb_v, cnt_v, cnt_now;
    logic [IndexW-1:0] idx;
    logic [3:0]        mask;
    int unsigned       span;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_index_i     <= RegFftSizeLog2;
    cfg_data_i      <= '0;
    in_valid_i      <= 1'b0;
    carrier_index_i <= '0;
    items_sent = 0;
    in_calm    = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // mode I straight out of reset: band edges and the centre
    picks = '{11'd0, 11'd1, 11'd767, 11'd1535, 11'd1536, 11'd2047};
    foreach (picks[k]) put_lookup(picks[k]);

    // smallest symbol, zero increment: every step keeps the same value, table ends short
    program_regs(4'hF, 11'd8, 11'd0, 11'd0, 11'd2047);
    picks = '{11'd0, 11'd255, 11'd256, 11'd2046, 11'd2047};
    foreach (picks[k]) put_lookup(picks[k]);

    // size above range with high bits set, zero carriers: nothing is valid
    program_regs(4'hF, 11'h7FF, 11'd2047, 11'd2047, 11'd0);
    picks = '{11'd0, 11'd2047};
    foreach (picks[k]) put_lookup(picks[k]);

    // size below range clamps to 256; narrow band
    program_regs(4'hF, 11'h7F3, 11'd13, 11'd100, 11'd60);
    picks = '{11'd0, 11'd30, 11'd59, 11'd60};
    foreach (picks[k]) put_lookup(picks[k]);

    // unit step over 2048: offsets run the full signed range
    program_regs(4'hF, 11'd11, 11'd1, 11'd0, 11'd2047);
    picks = '{11'd0, 11'd1, 11'd1024, 11'd2046};
    foreach (picks[k]) put_lookup(picks[k]);
    cnt_now = 11'd2047;

    while (items_sent < ItemTarget) begin
      mask  = 4'($urandom_range(1, 15));
      lg_v  = ($urandom_range(0, 3) == 0) ? CfgW'($urandom_range(0, 2047))
                                          : CfgW'($urandom_range(8, 11));
      inc_v = ($urandom_range(0, 7) == 0) ? CfgW'(2047 * $urandom_range(0, 1))
                                          : CfgW'($urandom_range(0, 2047));
      lb_v  = ($urandom_range(0, 4) < 3) ? CfgW'($urandom_range(0, 256))
                                         : CfgW'($urandom_range(0, 2047));
      case ($urandom_range(0, 5))
        0:       cnt_v = '0;
        1:       cnt_v = 11'd2047;
        default: cnt_v = CfgW'($urandom_range(64, 2047));
      endcase
      program_regs(mask, lg_v, inc_v, lb_v, cnt_v);
      if (mask[RegCarrierCnt]) cnt_now = cnt_v;
      span = $urandom_range(30, 110);
      repeat (span) begin
        // mostly in-band indices, the rest anywhere in the field
        if (cnt_now != 0 && $urandom_range(0, 3) != 0)
          idx = IndexW'($urandom_range(0, cnt_now - 1));
        else
          idx = IndexW'($urandom_range(0, 2047));
        put_lookup(idx);
      end
    end

    settle();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[files.f]
rtl/dfi_pkg.sv
rtl/dfi_step_unit.sv
rtl/dfi_build_ctrl.sv
rtl/dab_frequency_interleave_map.sv
dv/dfi_lookup_checker.sv
dv/tb_dab_frequency_interleave_map.sv
